// ----- rtl/core/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned DEF_MAX_BLOCKS   = 64;
  localparam int unsigned DEF_HEADER_BYTES = 16;

  localparam logic [31:0] FIRST_LENGTH = 32'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BADFREE = 2'd2;

  // effect of one finished request on the usage sums
  localparam logic [1:0] MV_NONE    = 2'd0;
  localparam logic [1:0] MV_TO_USED = 2'd1;
  localparam logic [1:0] MV_TO_FREE = 2'd2;
  localparam logic [1:0] MV_APPEND  = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        used;
  } blk_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [1:0]  move;
    logic [31:0] length;
  } scan_res_t;

endpackage

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// Top level: first-fit block allocator with usage statistics and result register.
// An allocate or free scans up to the N table entries in use (at most MAX_BLOCKS),
// reading one entry per cycle; a null free skips the scan. A new word is accepted only
// after the result of the last one has been loaded into the result register, so one
// word is in flight at a time. After reset and after each region_base write, the
// S_INIT state rebuilds table entry 0 before words are taken.
`timescale 1ns / 1ps

module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_region_base,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_address,
  output logic [1:0]  out_status,
  output logic [31:0] out_used_bytes,
  output logic [31:0] out_free_bytes,
  output logic [31:0] out_alloc_count,
  output logic [31:0] out_average_size
);
  import ffba_pkg::*;

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned SW = 32 + $clog2(MAX_BLOCKS + 1);

  logic        cfg_acc, in_acc, out_free, scan_ready, done;
  scan_res_t   res;
  logic        tbl_we, tbl_re;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  blk_entry_t  tbl_wdata, tbl_rdata;

  logic [31:0]   base_r, base_nxt;
  logic [31:0]   atot_r, atot_nxt;
  logic [31:0]   avg_r, avg_nxt;
  logic [SW-1:0] usum_r, usum_nxt;
  logic [SW-1:0] fsum_r, fsum_nxt;
  logic          oval_r, oval_nxt;
  logic [31:0]   oaddr_r, oaddr_nxt;
  logic [1:0]    ostat_r, ostat_nxt;
  logic [31:0]   oused_r, oused_nxt;
  logic [31:0]   ofree_r, ofree_nxt;
  logic [31:0]   ocnt_r, ocnt_nxt;
  logic [31:0]   oavg_r, oavg_nxt;
  logic [32:0]   avg_sum;
  logic [SW-1:0] len_w;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign in_ready  = scan_ready;
  assign in_acc    = in_valid && scan_ready;
  assign out_free  = !oval_r || out_ready;
  assign avg_sum   = {1'b0, avg_r} + {1'b0, in_request_size};
  assign len_w     = SW'(res.length);

  ffba_table #(
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  ffba_scan #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .init       (cfg_acc),
    .base       (base_r),
    .start      (in_acc),
    .op         (in_operation),
    .size       (in_request_size),
    .faddr      (in_free_address),
    .alloc_zero (atot_r == 32'd0),
    .out_free   (out_free),
    .ready      (scan_ready),
    .done       (done),
    .res        (res),
    .tbl_we     (tbl_we),
    .tbl_waddr  (tbl_waddr),
    .tbl_wdata  (tbl_wdata),
    .tbl_re     (tbl_re),
    .tbl_raddr  (tbl_raddr),
    .tbl_rdata  (tbl_rdata)
  );

  always_comb begin
    base_nxt  = base_r;
    atot_nxt  = atot_r;
    avg_nxt   = avg_r;
    usum_nxt  = usum_r;
    fsum_nxt  = fsum_r;
    oval_nxt  = oval_r;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    oused_nxt = oused_r;
    ofree_nxt = ofree_r;
    ocnt_nxt  = ocnt_r;
    oavg_nxt  = oavg_r;

    if (cfg_acc) begin
      base_nxt = cfg_region_base;
      atot_nxt = 32'd1;
      avg_nxt  = FIRST_LENGTH;
      usum_nxt = SW'(FIRST_LENGTH);
      fsum_nxt = '0;
    end else begin
      if (in_acc && (in_operation == OP_ALLOC)) begin
        if (atot_r != 32'hFFFF_FFFF) begin
          atot_nxt = atot_r + 32'd1;
        end
        avg_nxt = avg_sum[32:1];
      end
      if (done) begin
        case (res.move)
          MV_TO_USED: begin
            usum_nxt = usum_r + len_w;
            fsum_nxt = fsum_r - len_w;
          end
          MV_TO_FREE: begin
            usum_nxt = usum_r - len_w;
            fsum_nxt = fsum_r + len_w;
          end
          MV_APPEND: usum_nxt = usum_r + len_w;
          default: ;
        endcase
      end
    end

    if (done) begin
      oval_nxt  = 1'b1;
      oaddr_nxt = res.addr;
      ostat_nxt = res.status;
      oused_nxt = (|usum_nxt[SW-1:32]) ? 32'hFFFF_FFFF : usum_nxt[31:0];
      ofree_nxt = (|fsum_nxt[SW-1:32]) ? 32'hFFFF_FFFF : fsum_nxt[31:0];
      ocnt_nxt  = atot_r;
      oavg_nxt  = avg_r;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 32'd0;
      atot_r <= 32'd1;
      avg_r  <= FIRST_LENGTH;
      usum_r <= SW'(FIRST_LENGTH);
      fsum_r <= '0;
      oval_r <= 1'b0;
    end else begin
      base_r <= base_nxt;
      atot_r <= atot_nxt;
      avg_r  <= avg_nxt;
      usum_r <= usum_nxt;
      fsum_r <= fsum_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
    oused_r <= oused_nxt;
    ofree_r <= ofree_nxt;
    ocnt_r  <= ocnt_nxt;
    oavg_r  <= oavg_nxt;
  end

  assign out_valid          = oval_r;
  assign out_result_address = oaddr_r;
  assign out_status         = ostat_r;
  assign out_used_bytes     = oused_r;
  assign out_free_bytes     = ofree_r;
  assign out_alloc_count    = ocnt_r;
  assign out_average_size   = oavg_r;

endmodule

// ----- rtl/core/ffba_table.sv -----
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ffba_table #(
  parameter int unsigned DEPTH = ffba_pkg::DEF_MAX_BLOCKS,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  ffba_pkg::blk_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_addr,
  output ffba_pkg::blk_entry_t rd_data
);
  import ffba_pkg::*;

  blk_entry_t mem [DEPTH];
  blk_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/ffba_scan.sv -----
// Request sequencer: table init, first-fit / address scan, write-back and append.
`timescale 1ns / 1ps

module ffba_scan #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 init,
  input  logic [31:0]          base,
  input  logic                 start,
  input  logic                 op,
  input  logic [31:0]          size,
  input  logic [31:0]          faddr,
  input  logic                 alloc_zero,
  input  logic                 out_free,
  output logic                 ready,
  output logic                 done,
  output ffba_pkg::scan_res_t  res,
  output logic                 tbl_we,
  output logic [IW-1:0]        tbl_waddr,
  output ffba_pkg::blk_entry_t tbl_wdata,
  output logic                 tbl_re,
  output logic [IW-1:0]        tbl_raddr,
  input  ffba_pkg::blk_entry_t tbl_rdata
);
  import ffba_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [33:0] HDR   = 34'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
  localparam logic [34:0] LIMIT = 35'h1_0000_0000;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [32:0]   nhdr_r, nhdr_nxt;
  logic          op_r, op_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [31:0]   faddr_r, faddr_nxt;
  scan_res_t     res_r, res_nxt;

  logic [33:0] data34;
  logic [34:0] end35;
  logic        fmatch, fit, hit, last;

  assign data34 = {1'b0, nhdr_r} + HDR;
  assign end35  = {1'b0, data34} + {3'b0, size_r};
  assign fmatch = ({1'b0, tbl_rdata.start} + HDR[32:0]) == {1'b0, faddr_r};
  assign fit    = !tbl_rdata.used && (tbl_rdata.length >= size_r);
  assign hit    = (op_r == OP_ALLOC) ? fit : fmatch;
  assign last   = CW'(chk_r) == (cnt_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    cnt_nxt   = cnt_r;
    nhdr_nxt  = nhdr_r;
    op_nxt    = op_r;
    size_nxt  = size_r;
    faddr_nxt = faddr_r;
    res_nxt   = res_r;
    tbl_we    = 1'b0;
    tbl_waddr = chk_r;
    tbl_wdata = tbl_rdata;
    tbl_re    = 1'b0;
    tbl_raddr = chk_r + IW'(1);

    case (state_r)
      S_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = '0;
        tbl_wdata = '{start: base, length: FIRST_LENGTH, used: 1'b1};
        cnt_nxt   = CW'(1);
        nhdr_nxt  = {1'b0, base} + HDR[32:0] + {1'b0, FIRST_LENGTH};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = op;
          size_nxt  = size;
          faddr_nxt = faddr;
          if ((op == OP_FREE) && ((faddr == 32'd0) || alloc_zero)) begin
            res_nxt   = '{status: STAT_BADFREE, addr: 32'd0, move: MV_NONE, length: 32'd0};
            state_nxt = S_DONE;
          end else begin
            tbl_re    = 1'b1;
            tbl_raddr = '0;
            chk_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          tbl_we         = 1'b1;
          tbl_waddr      = chk_r;
          tbl_wdata.used = (op_r == OP_ALLOC);
          res_nxt.status = STAT_OK;
          res_nxt.length = tbl_rdata.length;
          if (op_r == OP_ALLOC) begin
            res_nxt.addr = tbl_rdata.start + 32'(HEADER_BYTES);
            res_nxt.move = MV_TO_USED;
          end else begin
            res_nxt.addr = 32'd0;
            res_nxt.move = tbl_rdata.used ? MV_TO_FREE : MV_NONE;
          end
          state_nxt = S_DONE;
        end else if (last) begin
          res_nxt = '{status: STAT_NOSPACE, addr: 32'd0, move: MV_NONE, length: 32'd0};
          if (op_r == OP_FREE) begin
            res_nxt.status = STAT_BADFREE;
          end else if ((cnt_r < MAXB) && (end35 <= LIMIT)) begin
            tbl_we    = 1'b1;
            tbl_waddr = cnt_r[IW-1:0];
            tbl_wdata = '{start: nhdr_r[31:0], length: size_r, used: 1'b1};
            cnt_nxt   = cnt_r + CW'(1);
            nhdr_nxt  = end35[32:0];
            res_nxt   = '{status: STAT_OK, addr: data34[31:0], move: MV_APPEND,
                          length: size_r};
          end
          state_nxt = S_DONE;
        end else begin
          tbl_re  = 1'b1;
          chk_nxt = chk_r + IW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase

    if (init) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    cnt_r   <= cnt_nxt;
    nhdr_r  <= nhdr_nxt;
    op_r    <= op_nxt;
    size_r  <= size_nxt;
    faddr_r <= faddr_nxt;
    res_r   <= res_nxt;
  end

  assign ready = (state_r == S_IDLE);
  assign done  = (state_r == S_DONE) && out_free;
  assign res   = res_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the first-fit block allocator core.
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned HDR  = DEF_HEADER_BYTES;
  localparam int unsigned MAXB = DEF_MAX_BLOCKS;
  localparam int unsigned SETTLE = MAXB + 6;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] used;
    logic [31:0] unused;
    logic [31:0] count;
    logic [31:0] avg;
  } alloc_word_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [31:0] size;
    logic [31:0] faddr;
    logic        typed;
    alloc_word_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_region_base = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_ALLOC;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_free_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_address;
  logic [1:0]  out_status;
  logic [31:0] out_used_bytes;
  logic [31:0] out_free_bytes;
  logic [31:0] out_alloc_count;
  logic [31:0] out_average_size;

  first_fit_block_allocator_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_region_base    (cfg_region_base),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_free_address    (in_free_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_used_bytes     (out_used_bytes),
    .out_free_bytes     (out_free_bytes),
    .out_alloc_count    (out_alloc_count),
    .out_average_size   (out_average_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator table and statistics as the block should hold them
  logic [31:0]     blk_start [MAXB];
  logic [31:0]     blk_len   [MAXB];
  logic            blk_used  [MAXB];
  int unsigned     blk_count;
  longint unsigned next_hdr;
  logic [31:0]     alloc_total;
  logic [31:0]     run_avg;

  alloc_word_t     expected_words[$];
  alloc_word_t     got_exp;
  int unsigned     errors = 0;
  bit              quiet = 1'b0;
  script_row_t     script[$];

  function automatic void reset_table(input logic [31:0] base);
    for (int i = 0; i < MAXB; i++) begin
      blk_start[i] = '0;
      blk_len[i]   = '0;
      blk_used[i]  = 1'b0;
    end
    blk_start[0] = base;
    blk_len[0]   = FIRST_LENGTH;
    blk_used[0]  = 1'b1;
    blk_count    = 1;
    next_hdr     = 64'(base) + HDR + FIRST_LENGTH;
    alloc_total  = 32'd1;
    run_avg      = FIRST_LENGTH;
  endfunction

  function automatic alloc_word_t serve_request(input logic op, input logic [31:0] size,
                                                input logic [31:0] faddr);
    alloc_word_t     w;
    longint unsigned data;
    longint unsigned u;
    longint unsigned f;
    bit              hit;
    w   = '0;
    hit = 1'b0;
    if (op == OP_ALLOC) begin
      if (alloc_total != 32'hFFFF_FFFF) alloc_total = alloc_total + 1;
      run_avg = 32'(({1'b0, run_avg} + {1'b0, size}) >> 1);
      for (int i = 0; i < blk_count; i++) begin
        if (!hit && !blk_used[i] && blk_len[i] >= size) begin
          blk_used[i] = 1'b1;
          w.addr = blk_start[i] + HDR;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        data = next_hdr + HDR;
        if (blk_count >= MAXB || data + size > 64'h1_0000_0000) begin
          w.status = STAT_NOSPACE;
        end else begin
          blk_start[blk_count] = next_hdr[31:0];
          blk_len[blk_count]   = size;
          blk_used[blk_count]  = 1'b1;
          blk_count++;
          next_hdr = data + size;
          w.addr = data[31:0];
        end
      end
    end else begin
      w.status = STAT_BADFREE;
      if (alloc_total != 0 && faddr != 0) begin
        for (int i = 0; i < blk_count; i++) begin
          if (!hit && 64'(blk_start[i]) + HDR == 64'(faddr)) begin
            blk_used[i] = 1'b0;
            w.status = STAT_OK;
            hit = 1'b1;
          end
        end
      end
    end
    u = 0;
    f = 0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_used[i]) u += blk_len[i];
      else f += blk_len[i];
    end
    w.used   = (u > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u[31:0];
    w.unused = (f > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : f[31:0];
    w.count  = alloc_total;
    w.avg    = run_avg;
    return w;
  endfunction

  function automatic alloc_word_t word(input logic [31:0] addr, input logic [1:0] status,
                                       input logic [31:0] used, input logic [31:0] unused,
                                       input logic [31:0] count, input logic [31:0] avg);
    word = '{addr: addr, status: status, used: used, unused: unused, count: count, avg: avg};
  endfunction

  function automatic script_row_t row(input row_kind_t kind, input logic op,
                                      input logic [31:0] size, input logic [31:0] faddr,
                                      input logic typed, input alloc_word_t want);
    row = '{kind: kind, op: op, size: size, faddr: faddr, typed: typed, want: want};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // result side: random back-pressure, in-order check against the oldest expectation
  always @(posedge clk) begin
    out_ready <= rst_n && (quiet || $urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, address", out_result_address, '0);
      end else begin
        got_exp = expected_words.pop_front();
        if (out_result_address !== got_exp.addr)
          report_mismatch("result_address", out_result_address, got_exp.addr);
        if (out_status !== got_exp.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, got_exp.status});
        if (out_used_bytes !== got_exp.used)
          report_mismatch("used_bytes", out_used_bytes, got_exp.used);
        if (out_free_bytes !== got_exp.unused)
          report_mismatch("free_bytes", out_free_bytes, got_exp.unused);
        if (out_alloc_count !== got_exp.count)
          report_mismatch("alloc_count", out_alloc_count, got_exp.count);
        if (out_average_size !== got_exp.avg)
          report_mismatch("average_size", out_average_size, got_exp.avg);
      end
    end
  end

  task automatic send_word(input logic op, input logic [31:0] size, input logic [31:0] faddr,
                           input logic typed, input alloc_word_t want);
    alloc_word_t w;
    while (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w = serve_request(op, size, faddr);
    expected_words.push_back(typed ? want : w);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_request_size <= size;
    in_free_address <= faddr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] base);
    cfg_valid       <= 1'b1;
    cfg_region_base <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reset_table(base);
  endtask

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] faddr;
    logic        op;
    int unsigned alloc_pct;
    int unsigned r;
    int unsigned idx;

    reset_table('0);
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h0, 1,
                         word(0, STAT_BADFREE, 4096, 0, 1, 4096)));
    script.push_back(row(ROW_REQ, OP_ALLOC, 0, 0, 1,
                         word(32'h1020, STAT_OK, 4096, 0, 2, 2048)));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h10, 1,
                         word(0, STAT_OK, 0, 4096, 2, 2048)));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h10, 0, '0));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h1021, 1,
                         word(0, STAT_BADFREE, 0, 4096, 2, 2048)));
    script.push_back(row(ROW_REQ, OP_ALLOC, 100, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 32'h8000_0000, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 32'h7FFF_E000, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 32'hFFFF_FFFF, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h1030, 0, '0));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h8000_1040, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 32'h7FFF_FFFF, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 0, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'hFFFF_FFFF, 0, '0));
    script.push_back(row(ROW_CFG, OP_ALLOC, 32'hFFFF_FFFF, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 0, 0, 1,
                         word(0, STAT_NOSPACE, 4096, 0, 2, 2048)));
    // block 0 data address wraps past 2^32, so the short address never matches
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'hF, 1,
                         word(0, STAT_BADFREE, 4096, 0, 2, 2048)));
    script.push_back(row(ROW_CFG, OP_ALLOC, 32'h7FFF_EFE0, 0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 32'h8000_0000, 0, 1,
                         word(32'h8000_0000, STAT_OK, 32'h8000_1000, 0, 2, 32'h4000_0800)));
    script.push_back(row(ROW_REQ, OP_ALLOC, 0, 0, 1,
                         word(0, STAT_NOSPACE, 32'h8000_1000, 0, 3, 32'h2000_0400)));
    script.push_back(row(ROW_REQ, OP_FREE, 0, 32'h7FFF_EFF0, 0, '0));
    script.push_back(row(ROW_REQ, OP_ALLOC, 0, 0, 0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_base(script[i].size);
      end else begin
        send_word(script[i].op, script[i].size, script[i].faddr, script[i].typed,
                  script[i].want);
      end
    end

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: base = '0;
        1: base = 32'hFFFF_0000 - $urandom_range(0, 32'h1000);
        2: base = $urandom();
        default: base = $urandom_range(0, 32'hFFFF);
      endcase
      drain();
      write_base(base);
      quiet = (p == 2);
      alloc_pct = (p == 0) ? 90 : $urandom_range(55, 75);
      for (int k = 0; k < 155; k++) begin
        if (k == 77) drain();
        op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, blk_count - 1);
        if (op == OP_ALLOC) begin
          if (r < 10) size = 0;
          else if (r < 50) size = $urandom_range(1, 256);
          else if (r < 85) size = $urandom_range(257, 8192);
          else if (r < 97) size = blk_len[idx];
          else size = $urandom();
          faddr = $urandom();
        end else begin
          size = $urandom();
          if (r < 65) faddr = blk_start[idx] + HDR;
          else if (r < 75) faddr = '0;
          else if (r < 85) faddr = blk_start[idx] + HDR + ($urandom_range(0, 1) ? 1 : -1);
          else faddr = $urandom();
        end
        send_word(op, size, faddr, 0, '0);
      end
    end
    quiet = 1'b0;

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
